>>> rtl/lstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstk_pkg
// Shared widths, types and constants for the lowest-score top-K selector.
// ----------------------------------------------------------------------------
package lstk_pkg;

    localparam int MAX_KEEP = 64;
    localparam int CNT_W    = 7;
    localparam int ADDR_W   = 64;
    localparam int SCORE_W  = 64;

    localparam logic [CNT_W-1:0] KEEP_RST = CNT_W'(MAX_KEEP);

    // one kept page
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef t_entry t_row [MAX_KEEP];

    // hand-off of a finished set to the output buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } t_load;

endpackage

>>> rtl/lowest_score_top_k_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_score_top_k_select
// Keeps the K lowest-scored pages of a set and emits them, highest first.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one page word per accepted cycle,
// address, score and a final flag. Non-final words are taken every cycle; the
// sorted keep row compares the score against all 64 cells in parallel.
// A final word closes the set: the kept pages move to the output row and the
// keep row empties, so the next set may stream in at once. A final word is
// stalled while the output row still holds an earlier set.
// Output channel (o_out_valid / i_out_stall): the kept pages, descending
// score, equal scores oldest first, o_run_last on the last one. After the final word
// is accepted, the output row shifts the top entry into place; the first
// word is valid after that, then one word per cycle while not stalled. A
// stalled word holds.
// Configuration: i_cfg_we writes keep_count (0 acts as 1, above 64 as 64);
// write only while idle.
// Reset (i_rst_n low, synchronous): keep_count returns to 64, both rows
// empty; no clearing pass.
// ----------------------------------------------------------------------------
module lowest_score_top_k_select
    import lstk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ADDR_W-1:0]  i_page_addr,
    input  logic [SCORE_W-1:0] i_page_score,
    input  logic               i_final_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_sel_addr,
    output logic [SCORE_W-1:0] o_sel_score,
    output logic               o_run_last
);

    logic [CNT_W-1:0] r_keep_count;
    logic             busy;
    logic             item_fire;
    t_load            load;
    t_row             row;

    // keep_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_RST;
        end else if (i_cfg_we) begin
            r_keep_count <= i_cfg_wdata;
        end
    end

    // hold a final word until the output row is free
    assign o_in_stall = busy && i_final_item;
    assign item_fire  = i_in_valid && !o_in_stall;

    lstk_keep_array u_keep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keep_count (r_keep_count),
        .i_item_fire  (item_fire),
        .i_page_addr  (i_page_addr),
        .i_page_score (i_page_score),
        .i_final_item (i_final_item),
        .o_load       (load),
        .o_row        (row)
    );

    lstk_emit_buf u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_row       (row),
        .i_out_stall (i_out_stall),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .o_sel_addr  (o_sel_addr),
        .o_sel_score (o_sel_score),
        .o_run_last  (o_run_last)
    );

endmodule

>>> rtl/lstk_keep_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstk_keep_array
// Sorted row of kept pages, lowest score in cell 0. Each word is compared
// against every held cell in parallel and inserted as it is accepted.
// ----------------------------------------------------------------------------
module lstk_keep_array
    import lstk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_keep_count,
    input  logic               i_item_fire,
    input  logic [ADDR_W-1:0]  i_page_addr,
    input  logic [SCORE_W-1:0] i_page_score,
    input  logic               i_final_item,
    output t_load              o_load,
    output t_row               o_row
);

    t_row               r_row;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;

    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   fill_eff;
    logic [MAX_KEEP-1:0] lt;
    logic [MAX_KEEP-1:0] gt;
    logic [MAX_KEEP-1:0] lt_below;
    logic               take;
    t_entry             new_entry;

    assign new_entry.addr  = i_page_addr;
    assign new_entry.score = i_page_score;

    // clamp the configured count into 1..MAX_KEEP
    always_comb begin
        if (i_keep_count == '0) begin
            limit = CNT_W'(1);
        end else if (i_keep_count > CNT_W'(MAX_KEEP)) begin
            limit = CNT_W'(MAX_KEEP);
        end else begin
            limit = i_keep_count;
        end
    end

    // drop the highest entries that no longer fit a lowered limit
    assign fill_eff = (r_fill > limit) ? limit : r_fill;

    // compare the new score against every held cell
    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cmp
            logic in_use;
            assign in_use = CNT_W'(gi) < fill_eff;
            assign lt[gi] = in_use && (r_row[gi].score < i_page_score);
            assign gt[gi] = in_use && (r_row[gi].score > i_page_score);
        end
    endgenerate

    assign lt_below = {lt[MAX_KEEP-2:0], 1'b1};

    // take the page if there is room, or if it beats the highest held score
    assign take = (fill_eff < limit) || (|gt);

    always_comb begin
        if (!take) begin
            n_fill = fill_eff;
        end else if (fill_eff == limit) begin
            n_fill = limit;
        end else begin
            n_fill = fill_eff + CNT_W'(1);
        end
    end

    // insert: cells below the slot hold, the slot takes the new page,
    // cells above shift up by one (the top one falls off when full)
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_ins
            t_entry prev;
            if (gi == 0) begin : g_first
                assign prev = new_entry;
            end else begin : g_rest
                assign prev = r_row[gi-1];
            end
            always_comb begin
                if (!take || lt[gi]) begin
                    o_row[gi] = r_row[gi];
                end else if (lt_below[gi]) begin
                    o_row[gi] = new_entry;
                end else begin
                    o_row[gi] = prev;
                end
            end
        end
    endgenerate

    // update the row on every accepted word
    always_ff @(posedge i_clk) begin
        if (i_item_fire) begin
            r_row <= o_row;
        end
    end

    // empty the set after the final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_item_fire) begin
            r_fill <= i_final_item ? '0 : n_fill;
        end
    end

    assign o_load.load  = i_item_fire && i_final_item;
    assign o_load.count = n_fill;

endmodule

>>> rtl/lstk_emit_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstk_emit_buf
// Output shift row. Takes a finished set, shifts it up until the highest
// entry reaches the top cell, then hands out one word per taken cycle.
// ----------------------------------------------------------------------------
module lstk_emit_buf
    import lstk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_load              i_load,
    input  t_row               i_row,
    input  logic               i_out_stall,
    output logic               o_busy,
    output logic               o_out_valid,
    output logic [ADDR_W-1:0]  o_sel_addr,
    output logic [SCORE_W-1:0] o_sel_score,
    output logic               o_run_last
);

    localparam int TOP = MAX_KEEP - 1;

    t_row                r_buf;
    logic [MAX_KEEP-1:0] r_vld;
    logic [MAX_KEEP-1:0] load_vld;
    logic                shift;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_lv
            assign load_vld[gi] = CNT_W'(gi) < i_load.count;
        end
    endgenerate

    assign o_busy = |r_vld;

    // advance while aligning, or when the top word is taken
    assign shift = o_busy && (!r_vld[TOP] || !i_out_stall);

    // hold or shift the payload
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_buf <= i_row;
        end else if (shift) begin
            for (int i = MAX_KEEP - 1; i > 0; i--) begin
                r_buf[i] <= r_buf[i-1];
            end
        end
    end

    // valid bits follow the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_load.load) begin
            r_vld <= load_vld;
        end else if (shift) begin
            r_vld <= {r_vld[MAX_KEEP-2:0], 1'b0};
        end
    end

    assign o_out_valid = r_vld[TOP];
    assign o_sel_addr  = r_buf[TOP].addr;
    assign o_sel_score = r_buf[TOP].score;
    assign o_run_last  = !r_vld[TOP-1];

endmodule

>>> tb/tb_lowest_score_top_k_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_score_top_k_select
// Self-checking bench for the lowest-score top-K selector. A behavioral copy of
// the sorted keep row predicts every emitted page word. Directed sets cover the
// score extremes, ties at the highest kept score, short sets, a limit lowered
// in the middle of a set and a zero limit. Random sets then run under
// several keep_count settings with random idle cycles on both sides, one long
// receiver hold that backs up the block, and full drains between settings.
// ----------------------------------------------------------------------------
module tb_lowest_score_top_k_select;
    import lstk_pkg::*;

    localparam logic [SCORE_W-1:0] SCORE_MAX  = {SCORE_W{1'b1}};
    localparam logic [ADDR_W-1:0]  ADDR_MAX   = {ADDR_W{1'b1}};
    localparam int                 SETTLE_CYC = 80;   // margin for the output row's alignment shift
    localparam int                 HOLD_CYC   = 400;
    localparam int                 ITEM_GOAL  = 280;

    // one expected output word
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SCORE_W-1:0] score;
        logic               last;
    } t_sel_word;

    // ------------------------------------------------------------------------
    // Keep-row predictor and expected-word store
    // ------------------------------------------------------------------------
    class cold_page_tracker;
        logic [CNT_W-1:0] keep_reg;
        t_entry           row [MAX_KEEP];   // index 0 is emitted first
        int               fill;
        t_sel_word        due_sel [$];
        int               errors;

        function new();
            keep_reg = KEEP_RST;
            fill     = 0;
            errors   = 0;
        endfunction

        function void set_keep(logic [CNT_W-1:0] value);
            keep_reg = value;
        endfunction

        function int limit();
            if (keep_reg == 0) return 1;
            if (keep_reg > MAX_KEEP) return MAX_KEEP;
            return int'(keep_reg);
        endfunction

        // remove the highest-scored, oldest-among-ties entry
        function void drop_top();
            if (fill == 0) return;
            for (int i = 0; i < fill - 1; i++) row[i] = row[i+1];
            fill--;
        endfunction

        // descending score, new entry after older equals
        function void insert_page(logic [ADDR_W-1:0] addr, logic [SCORE_W-1:0] score);
            int pos;
            pos = 0;
            while (pos < fill && row[pos].score >= score) pos++;
            for (int i = fill; i > pos; i--) row[i] = row[i-1];
            row[pos].addr  = addr;
            row[pos].score = score;
            fill++;
        endfunction

        // note an accepted page word; a final word queues the whole run
        function void take_page(logic [ADDR_W-1:0] addr, logic [SCORE_W-1:0] score,
                                logic fin);
            t_sel_word w;
            int        lim;
            lim = limit();
            while (fill > lim) drop_top();
            if (fill < lim) begin
                insert_page(addr, score);
            end else if (score < row[0].score) begin
                drop_top();
                insert_page(addr, score);
            end
            if (fin) begin
                for (int i = 0; i < fill; i++) begin
                    w.addr  = row[i].addr;
                    w.score = row[i].score;
                    w.last  = (i == fill - 1);
                    due_sel.push_back(w);
                end
                fill = 0;
            end
        endfunction

        task flag_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // compare one accepted output word with the oldest expectation
        task match_selected(logic [ADDR_W-1:0] addr, logic [SCORE_W-1:0] score,
                            logic last);
            t_sel_word w;
            if (due_sel.size() == 0) begin
                flag_mismatch($sformatf("unexpected word addr=%h score=%h", addr, score));
                return;
            end
            w = due_sel.pop_front();
            if (addr !== w.addr)
                flag_mismatch($sformatf("sel_addr %h, want %h", addr, w.addr));
            if (score !== w.score)
                flag_mismatch($sformatf("sel_score %h, want %h", score, w.score));
            if (last !== w.last)
                flag_mismatch($sformatf("run_last %b, want %b", last, w.last));
        endtask

        task flag_leftovers();
            if (due_sel.size() != 0)
                flag_mismatch($sformatf("%0d expected words never came", due_sel.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CNT_W-1:0]   i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [ADDR_W-1:0]  i_page_addr;
    logic [SCORE_W-1:0] i_page_score;
    logic               i_final_item;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [ADDR_W-1:0]  o_sel_addr;
    logic [SCORE_W-1:0] o_sel_score;
    logic               o_run_last;

    lowest_score_top_k_select uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_page_addr  (i_page_addr),
        .i_page_score (i_page_score),
        .i_final_item (i_final_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sel_addr   (o_sel_addr),
        .o_sel_score  (o_sel_score),
        .o_run_last   (o_run_last)
    );

    cold_page_tracker tracker;
    bit               pace_on;     // random idle cycles on both sides
    bit               hold_req;    // ask the receiver for one long hold
    int               pages_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard limit on run time
    initial begin
        #20_000_000;
        $display("[lowest_score_top_k_select] ERROR");
        $finish;
    end

    // check every accepted output word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.match_selected(o_sel_addr, o_sel_score, o_run_last);
    end

    // receiver: random stall before each word, one long hold on request
    initial begin
        int wait_cyc;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            wait_cyc = pace_on ? $urandom_range(0, 9) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                wait_cyc = HOLD_CYC;
            end
            if (wait_cyc != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cyc) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // score by set flavor: full range, narrow range for ties, or extremes
    function automatic logic [SCORE_W-1:0] pick_score(int flavor);
        case (flavor)
            0: return rand64();
            1: return SCORE_W'($urandom_range(0, 7));
            default: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return SCORE_W'(1);
                    2: return SCORE_MAX - 1;
                    default: return SCORE_MAX;
                endcase
            end
        endcase
    endfunction

    // offer one page word after a random gap and hold it until taken
    task automatic send_page(logic [ADDR_W-1:0] addr, logic [SCORE_W-1:0] score,
                             logic fin);
        int gap;
        gap = pace_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_page_addr  <= addr;
        i_page_score <= score;
        i_final_item <= fin;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        tracker.take_page(addr, score, fin);
        pages_sent++;
    endtask

    // stop offering, wait for every expected word, then let the block settle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.due_sel.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write keep_count; only called while idle
    task automatic put_keep(logic [CNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_keep(value);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CNT_W-1:0] keep_val;
        logic [ADDR_W-1:0] addr;
        int               phase;
        int               n_sets;
        int               set_len;
        int               lim;
        int               flavor;

        tracker      = new();
        pace_on      = 1'b0;
        hold_req     = 1'b0;
        pages_sent   = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        i_in_valid   <= 1'b0;
        i_page_addr  <= '0;
        i_page_score <= '0;
        i_final_item <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ties at the top: equal scores are not taken, oldest equal is displaced
        put_keep(CNT_W'(3));
        send_page('0, SCORE_MAX, 1'b0);
        send_page(ADDR_MAX, '0, 1'b0);
        send_page(64'h1111, 64'd7, 1'b0);
        send_page(64'h2222, 64'd7, 1'b0);
        send_page(64'h3333, 64'd7, 1'b0);
        send_page(64'h4444, 64'd5, 1'b0);
        send_page(64'h5555, 64'd7, 1'b1);
        settle();

        // fewer pages than the limit, emitted sorted; then a one-page set
        put_keep(KEEP_RST);
        send_page(64'hA, 64'd5, 1'b0);
        send_page(64'hB, 64'd9, 1'b0);
        send_page(64'hC, 64'd1, 1'b1);
        send_page(ADDR_MAX, SCORE_MAX, 1'b1);
        settle();

        // limit lowered in the middle of a set
        for (int i = 0; i < 6; i++)
            send_page(ADDR_W'(i + 16), SCORE_W'(60 - 10 * i), 1'b0);
        settle();
        put_keep(CNT_W'(2));
        send_page(64'h77, 64'd15, 1'b1);
        settle();

        // zero limit acts as one
        put_keep('0);
        send_page(64'h81, 64'd8, 1'b0);
        send_page(64'h82, 64'd3, 1'b0);
        send_page(64'h83, 64'd9, 1'b1);
        settle();

        // random sets under changing limits; always reach the long-hold phase
        phase = 0;
        while (pages_sent < ITEM_GOAL || phase <= 2) begin
            case (phase)
                0: keep_val = CNT_W'(1);
                1: keep_val = KEEP_RST;
                2: keep_val = '1;
                3: keep_val = '0;
                default: keep_val = ($urandom_range(0, 2) == 0) ?
                                    CNT_W'($urandom_range(2, 8)) :
                                    CNT_W'($urandom_range(1, 127));
            endcase
            put_keep(keep_val);
            lim     = tracker.limit();
            pace_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            n_sets  = $urandom_range(2, 5);
            // back up the output side while short sets keep arriving
            if (phase == 2) begin
                hold_req = 1'b1;
                n_sets   = 8;
            end
            for (int s = 0; s < n_sets && (pages_sent < ITEM_GOAL || phase == 2); s++) begin
                flavor = $urandom_range(0, 2);
                if (phase == 2)
                    set_len = $urandom_range(1, 4);
                else if ($urandom_range(0, 7) == 0)
                    set_len = $urandom_range(lim, lim + 8);
                else
                    set_len = $urandom_range(1, (lim + 4 < 20) ? lim + 4 : 20);
                for (int i = 0; i < set_len; i++) begin
                    case ($urandom_range(0, 9))
                        0: addr = '0;
                        1: addr = ADDR_MAX;
                        default: addr = rand64();
                    endcase
                    send_page(addr, pick_score(flavor), i == set_len - 1);
                end
            end
            settle();
            phase++;
        end

        settle();
        tracker.flag_leftovers();
        if (tracker.errors == 0)
            $display("[lowest_score_top_k_select] OK");
        else
            $display("[lowest_score_top_k_select] ERROR");
        $finish;
    end

endmodule
